@@ rtl/core/csp_pkg.sv @@
`timescale 1ns / 1ps

package csp_pkg;

   localparam int MaxChars = 17;

   localparam logic [7:0] SlashChar = 8'h2F;
   localparam logic [7:0] SpaceChar = 8'h20;
   localparam logic [7:0] TabChar   = 8'h09;
   localparam logic [7:0] CrChar    = 8'h0D;
   localparam logic [7:0] UpperA    = 8'h41;
   localparam logic [7:0] UpperZ    = 8'h5A;
   localparam logic [7:0] LowerA    = 8'h61;
   localparam logic [7:0] LowerZ    = 8'h7A;
   localparam logic [7:0] Digit0    = 8'h30;
   localparam logic [7:0] Digit9    = 8'h39;

   localparam logic [3:0] SegLenMax   = 4'd15;
   localparam logic [2:0] LetterRunMax = 3'd7;

   typedef enum logic [1:0] {
      TRIM_LEAD = 2'd0,
      TRIM_BODY = 2'd1,
      TRIM_TAIL = 2'd2
   } trim_phase_type;

   typedef struct packed {
      trim_phase_type trim_phase;
      logic [4:0]     char_count;
      logic [1:0]     segment_index;
      logic [3:0]     segment_length;
      logic [2:0]     letter_run;
      logic           digit_before_run;
      logic           error_seen;
      logic [3:0]     saved_len0;
      logic [3:0]     saved_len1;
      logic           saved_base0;
      logic           saved_base1;
   } scan_state_type;

   typedef struct packed {
      logic       valid_res;
      logic [4:0] full_len;
      logic [2:0] base_start;
      logic [3:0] base_len;
      logic [3:0] suffix_start;
      logic [2:0] suffix_len;
      logic [2:0] op_prefix_start;
      logic [3:0] op_prefix_len;
   } result_type;

   localparam scan_state_type ScanReset = '{
      trim_phase:       TRIM_LEAD,
      char_count:       5'd0,
      segment_index:    2'd0,
      segment_length:   4'd0,
      letter_run:       3'd0,
      digit_before_run: 1'b0,
      error_seen:       1'b0,
      saved_len0:       4'd0,
      saved_len1:       4'd0,
      saved_base0:      1'b0,
      saved_base1:      1'b0
   };

   // segment holds alphanumerics, a digit, then 1-4 letters
   function automatic logic seg_is_base(logic [3:0] seg_len, logic [2:0] run, logic dig_seen);
      logic [4:0] lo;
      logic [4:0] hi;
      lo = {2'b00, run} + 5'd2;
      hi = {2'b00, run} + 5'd4;
      return dig_seen && (run >= 3'd1) && (run <= 3'd4)
             && ({1'b0, seg_len} >= lo) && ({1'b0, seg_len} <= hi);
   endfunction

   function automatic logic len_in(logic [3:0] v, logic [3:0] lo, logic [3:0] hi);
      return (v >= lo) && (v <= hi);
   endfunction

endpackage

@@ rtl/core/csp_scan.sv @@
`timescale 1ns / 1ps

module csp_scan (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    take,
   input  logic [7:0]              char_in,
   input  logic                    is_last,
   output csp_pkg::scan_state_type snap
);

   csp_pkg::scan_state_type state_ff;
   csp_pkg::scan_state_type state_in;
   csp_pkg::scan_state_type nxt;

   logic       up;
   logic       dig;
   logic       ws;
   logic       slash;
   logic       full;

   always_comb begin
      up    = ((char_in >= csp_pkg::UpperA) && (char_in <= csp_pkg::UpperZ))
              || ((char_in >= csp_pkg::LowerA) && (char_in <= csp_pkg::LowerZ));
      dig   = (char_in >= csp_pkg::Digit0) && (char_in <= csp_pkg::Digit9);
      ws    = (char_in == csp_pkg::SpaceChar)
              || ((char_in >= csp_pkg::TabChar) && (char_in <= csp_pkg::CrChar));
      slash = (char_in == csp_pkg::SlashChar);
      full  = (state_ff.char_count >= 5'(csp_pkg::MaxChars));

      nxt = state_ff;
      if (ws) begin
         if (state_ff.trim_phase == csp_pkg::TRIM_BODY) begin
            nxt.trim_phase = csp_pkg::TRIM_TAIL;
         end
      end else if (state_ff.trim_phase == csp_pkg::TRIM_TAIL) begin
         nxt.error_seen = 1'b1;
      end else begin
         nxt.trim_phase = csp_pkg::TRIM_BODY;
         if (slash) begin
            if (full) begin
               nxt.error_seen = 1'b1;
            end else begin
               nxt.char_count = state_ff.char_count + 5'd1;
            end
            if (state_ff.segment_index >= 2'd2) begin
               nxt.error_seen = 1'b1;
            end else begin
               if (state_ff.segment_index == 2'd0) begin
                  nxt.saved_len0  = state_ff.segment_length;
                  nxt.saved_base0 = csp_pkg::seg_is_base(state_ff.segment_length,
                     state_ff.letter_run, state_ff.digit_before_run);
               end else begin
                  nxt.saved_len1  = state_ff.segment_length;
                  nxt.saved_base1 = csp_pkg::seg_is_base(state_ff.segment_length,
                     state_ff.letter_run, state_ff.digit_before_run);
               end
               nxt.segment_index = state_ff.segment_index + 2'd1;
            end
            nxt.segment_length   = 4'd0;
            nxt.letter_run       = 3'd0;
            nxt.digit_before_run = 1'b0;
         end else if (!up && !dig) begin
            nxt.error_seen = 1'b1;
         end else begin
            if (full) begin
               nxt.error_seen = 1'b1;
            end else begin
               nxt.char_count = state_ff.char_count + 5'd1;
            end
            if (state_ff.segment_length < csp_pkg::SegLenMax) begin
               nxt.segment_length = state_ff.segment_length + 4'd1;
            end
            if (dig) begin
               nxt.letter_run       = 3'd0;
               nxt.digit_before_run = 1'b1;
            end else if (state_ff.letter_run < csp_pkg::LetterRunMax) begin
               nxt.letter_run = state_ff.letter_run + 3'd1;
            end
         end
      end

      state_in = state_ff;
      if (take) begin
         state_in = is_last ? csp_pkg::ScanReset : nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csp_pkg::ScanReset;
      end else begin
         state_ff <= state_in;
      end
   end

   assign snap = nxt;

endmodule

@@ rtl/core/csp_eval.sv @@
`timescale 1ns / 1ps

module csp_eval (
   input  csp_pkg::scan_state_type snap,
   output csp_pkg::result_type     result
);

   logic [3:0] l0;
   logic [3:0] l1;
   logic [3:0] l2;
   logic       b0;
   logic       b1;
   logic       cur_base;
   logic       two_seg;
   logic       ok;
   logic [4:0] bs;
   logic [3:0] bl;
   logic [4:0] ss;
   logic [3:0] sl;
   logic [4:0] ps;
   logic [3:0] pl;

   always_comb begin
      cur_base = csp_pkg::seg_is_base(snap.segment_length, snap.letter_run,
                                      snap.digit_before_run);
      l0 = (snap.segment_index == 2'd0) ? snap.segment_length : snap.saved_len0;
      b0 = (snap.segment_index == 2'd0) ? cur_base : snap.saved_base0;
      l1 = (snap.segment_index == 2'd1) ? snap.segment_length : snap.saved_len1;
      b1 = (snap.segment_index == 2'd1) ? cur_base : snap.saved_base1;
      l2 = snap.segment_length;
      two_seg = 1'b0;

      bs = 5'd0;
      bl = 4'd0;
      ss = 5'd0;
      sl = 4'd0;

      unique case (snap.segment_index)
         2'd0: begin
            ok = b0;
            bl = l0;
         end
         2'd1: begin
            two_seg = 1'b1;
            ok = (csp_pkg::len_in(l0, 4'd1, 4'd3) && b1)
                 || (b0 && csp_pkg::len_in(l1, 4'd1, 4'd4));
            if (b1) begin
               bs = {1'b0, l0} + 5'd1;
               bl = l1;
            end else begin
               bl = l0;
               ss = {1'b0, l0} + 5'd1;
               sl = l1;
            end
         end
         default: begin
            two_seg = 1'b1;
            ok = csp_pkg::len_in(l0, 4'd1, 4'd3) && b1 && csp_pkg::len_in(l2, 4'd1, 4'd4);
            bs = {1'b0, l0} + 5'd1;
            bl = l1;
            ss = {1'b0, l0} + {1'b0, l1} + 5'd2;
            sl = l2;
         end
      endcase

      if (snap.error_seen || (snap.char_count > 5'(csp_pkg::MaxChars))) begin
         ok = 1'b0;
      end

      if (two_seg && !b0) begin
         ps = 5'd0;
         pl = l0;
      end else begin
         ps = bs;
         pl = bl;
      end

      result.valid_res       = ok;
      result.full_len        = ok ? snap.char_count : 5'd0;
      result.base_start      = ok ? bs[2:0] : 3'd0;
      result.base_len        = ok ? bl : 4'd0;
      result.suffix_start    = ok ? ss[3:0] : 4'd0;
      result.suffix_len      = ok ? sl[2:0] : 3'd0;
      result.op_prefix_start = ok ? ps[2:0] : 3'd0;
      result.op_prefix_len   = ok ? pl : 4'd0;
   end

endmodule

@@ rtl/core/callsign_split_parser.sv @@
`timescale 1ns / 1ps
// rsp_tvalid is registered, set when the tlast word leaves the input register
// one word per cycle unless tlast waits on rsp_tready; scan state updates per word
// one result word per callsign, held in an output register until taken
// synchronous active-high reset clears the input, scan state and output valid

module callsign_split_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // char_in[7:0]
   input  logic        req_tlast,   // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // valid_res[0], full_len[5:1], base_start[8:6], base_len[12:9],
   // suffix_start[16:13], suffix_len[19:17], op_prefix_start[22:20],
   // op_prefix_len[26:23], zero[31:27]
   output logic [31:0] rsp_tdata
);

   logic                    in_valid_ff;
   logic                    in_valid_in;
   logic [7:0]              in_char_ff;
   logic                    in_last_ff;
   logic                    advance;
   logic                    out_valid_ff;
   logic                    out_valid_in;
   csp_pkg::result_type     out_ff;
   csp_pkg::result_type     out_in;
   csp_pkg::scan_state_type snap;
   csp_pkg::result_type     result;

   csp_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .take    (advance),
      .char_in (in_char_ff),
      .is_last (in_last_ff),
      .snap    (snap)
   );

   csp_eval u_eval (
      .snap   (snap),
      .result (result)
   );

   always_comb begin
      advance      = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_tready);
      req_tready   = !in_valid_ff || advance;
      in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_in       = out_ff;
      if (advance && in_last_ff) begin
         out_valid_in = 1'b1;
         out_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_ff.op_prefix_len, out_ff.op_prefix_start,
                        out_ff.suffix_len, out_ff.suffix_start, out_ff.base_len,
                        out_ff.base_start, out_ff.full_len, out_ff.valid_res};

endmodule
